// ===== rtl/scsa_pkg.sv =====
// Shared types and constants for the size-class slot allocator.
// Used by scsa_ctrl, scsa_dp and size_class_slot_allocator; depends on nothing.
package scsa_pkg;

  // size class table, in bytes, smallest first
  localparam int SIZE_TABLE_LEN = 11;
  localparam logic [7:0] CLASS_BYTES [SIZE_TABLE_LEN] =
    '{8'd4, 8'd8, 8'd16, 8'd24, 8'd32, 8'd40, 8'd48, 8'd64, 8'd80, 8'd96, 8'd128};

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // capture the incoming word
    logic rd_issue;     // read link RAM at the current list head
    logic exec_commit;  // finish a free, fresh grant or error
    logic pop_commit;   // finish a free-list pop
  } scsa_cmd_t;

endpackage

// ===== rtl/size_class_slot_allocator.sv =====
// Top level of the size-class slot allocator: stream ports, sequencer and datapath.
// Depends on scsa_pkg, scsa_ctrl and scsa_dp.
//
// Slot allocator over up to eleven size classes (4..128 bytes). An allocate word
// picks the smallest class holding request_size plus one tag byte, pops that
// class's LIFO free list, or else grants the next never-used slot of the class.
// A free word pushes (free_class, free_slot) onto its class list; bad handles are
// dropped, double frees are not detected. Every input word yields exactly one
// result word. One word is in flight at a time: a free, fresh grant or error goes
// from accept to execute; a pop from a free list issues the synchronous link RAM
// read at the list head, then adds a pop state for the head write-back. The
// result sits in an output register, so the next word is accepted while it waits.
// The link RAM needs no clearing after reset; the block is ready at once.
module size_class_slot_allocator
  import scsa_pkg::*;
#(
  parameter int SLOTS_PER_CLASS = 4096,
  parameter int NUM_CLASSES     = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] request_size, [19:16] free_class, [31:20] free_slot
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [5:2] granted_class, [17:6] granted_slot
);

  scsa_cmd_t   cmd;
  logic        pop_pending;
  logic [1:0]  status;
  logic [3:0]  granted_class;
  logic [11:0] granted_slot;

  scsa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .pop_pending (pop_pending),
    .cmd         (cmd)
  );

  scsa_dp #(
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_tuser),
    .in_request_size   (in_tdata[15:0]),
    .in_free_class     (in_tdata[19:16]),
    .in_free_slot      (in_tdata[31:20]),
    .pop_pending       (pop_pending),
    .out_status        (status),
    .out_granted_class (granted_class),
    .out_granted_slot  (granted_slot)
  );

  // pack the result word
  assign out_tdata = {6'd0, granted_slot, granted_class, status};

endmodule

// ===== rtl/scsa_ctrl.sv =====
// Sequencer for the size-class slot allocator: accept, execute, optional pop.
// Depends on scsa_pkg; drives scsa_dp through scsa_cmd_t and owns out_tvalid.
module scsa_ctrl
  import scsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  logic      pop_pending,
  output scsa_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a word this cycle
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pop_pending) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_POP;
        end else if (out_free) begin
          cmd.exec_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          cmd.pop_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on a finished word, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec_commit || cmd.pop_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/scsa_dp.sv =====
// Datapath for the size-class slot allocator: class select, list heads,
// fresh counters, link RAM and result register. Depends on scsa_pkg.
module scsa_dp
  import scsa_pkg::*;
#(
  parameter int SLOTS_PER_CLASS = 4096,
  parameter int NUM_CLASSES     = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  scsa_cmd_t   cmd,
  input  logic        in_kind,
  input  logic [15:0] in_request_size,
  input  logic [3:0]  in_free_class,
  input  logic [11:0] in_free_slot,
  output logic        pop_pending,
  output logic [1:0]  out_status,
  output logic [3:0]  out_granted_class,
  output logic [11:0] out_granted_slot
);

  localparam int NCLS      = (NUM_CLASSES < SIZE_TABLE_LEN) ? NUM_CLASSES : SIZE_TABLE_LEN;
  localparam int CLS_W     = (NCLS > 1) ? $clog2(NCLS) : 1;
  localparam int SLOT_W    = $clog2(SLOTS_PER_CLASS);
  localparam int MEM_DEPTH = NCLS << SLOT_W;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int LINK_W    = SLOT_W + 1;

  // captured request
  logic              kind_r;
  logic [CLS_W-1:0]  cls_r;
  logic [SLOT_W-1:0] slot_r;
  logic              bad_r;

  // per-class state
  logic              head_vld_r [NCLS];
  logic [SLOT_W-1:0] head_idx_r [NCLS];
  logic [SLOT_W:0]   fresh_r    [NCLS];

  // link RAM: valid bit and next slot, addressed by {class, slot}
  logic [LINK_W-1:0] link_mem [MEM_DEPTH];
  logic [LINK_W-1:0] rdata_r;

  // result register
  logic [1:0]  status_r;
  logic [3:0]  gcls_r;
  logic [11:0] gslot_r;

  logic [16:0]       need;
  logic              alloc_found;
  logic [CLS_W-1:0]  alloc_cls;
  logic              free_ok;
  logic              cur_vld;
  logic [SLOT_W-1:0] cur_idx;
  logic [SLOT_W:0]   cur_fresh;
  logic [SLOT_W-1:0] pop_slot;
  logic              fresh_avail;
  logic [AW-1:0]     mem_addr;
  logic [1:0]        res_status;
  logic [3:0]        res_cls;
  logic [11:0]       res_slot;

  // smallest class that holds request plus tag byte
  always_comb begin
    need        = {1'b0, in_request_size} + 17'd1;
    alloc_found = 1'b0;
    alloc_cls   = '0;
    for (int c = NCLS - 1; c >= 0; c--) begin
      if ({9'd0, CLASS_BYTES[c]} >= need) begin
        alloc_found = 1'b1;
        alloc_cls   = CLS_W'(c);
      end
    end
  end

  // free handle range check
  assign free_ok = (in_free_class < 4'(NCLS)) &&
                   ({5'd0, in_free_slot} < 17'(SLOTS_PER_CLASS));

  // capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      slot_r <= SLOT_W'(in_free_slot);
      if (in_kind == KIND_FREE) begin
        bad_r <= !free_ok;
        cls_r <= free_ok ? CLS_W'(in_free_class) : '0;
      end else begin
        bad_r <= !alloc_found;
        cls_r <= alloc_cls;
      end
    end
  end

  // current class view
  assign cur_vld     = head_vld_r[cls_r];
  assign cur_idx     = head_idx_r[cls_r];
  assign cur_fresh   = fresh_r[cls_r];
  assign pop_slot    = ({1'b0, cur_idx} < LINK_W'(SLOTS_PER_CLASS)) ? cur_idx : '0;
  assign fresh_avail = ({1'b0, cur_fresh} < (SLOT_W + 2)'(SLOTS_PER_CLASS));
  assign pop_pending = (kind_r == KIND_ALLOC) && !bad_r && cur_vld;

  // link RAM port: frees write at the freed slot, pops read at the head
  assign mem_addr = (kind_r == KIND_FREE) ? AW'({cls_r, slot_r}) : AW'({cls_r, pop_slot});

  always_ff @(posedge clk) begin
    if (cmd.exec_commit && kind_r == KIND_FREE && !bad_r) begin
      link_mem[mem_addr] <= {cur_vld, cur_idx};
    end
    if (cmd.rd_issue) begin
      rdata_r <= link_mem[mem_addr];
    end
  end

  // list heads and fresh counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCLS; c++) begin
        head_vld_r[c] <= 1'b0;
        fresh_r[c]    <= '0;
      end
    end else begin
      if (cmd.pop_commit) begin
        head_vld_r[cls_r] <= rdata_r[SLOT_W];
        head_idx_r[cls_r] <= rdata_r[SLOT_W-1:0];
      end else if (cmd.exec_commit && !bad_r) begin
        if (kind_r == KIND_FREE) begin
          head_vld_r[cls_r] <= 1'b1;
          head_idx_r[cls_r] <= slot_r;
        end else if (fresh_avail) begin
          fresh_r[cls_r] <= cur_fresh + 1'b1;
        end
      end
    end
  end

  // result word
  always_comb begin
    res_status = STAT_OK;
    res_cls    = '0;
    res_slot   = '0;
    if (cmd.pop_commit) begin
      res_cls  = 4'(cls_r);
      res_slot = 12'(pop_slot);
    end else if (kind_r == KIND_ALLOC) begin
      if (bad_r) begin
        res_status = STAT_TOO_LARGE;
      end else if (fresh_avail) begin
        res_cls  = 4'(cls_r);
        res_slot = 12'(cur_fresh);
      end else begin
        res_status = STAT_EXHAUSTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_commit || cmd.pop_commit) begin
      status_r <= res_status;
      gcls_r   <= res_cls;
      gslot_r  <= res_slot;
    end
  end

  assign out_status        = status_r;
  assign out_granted_class = gcls_r;
  assign out_granted_slot  = gslot_r;

endmodule
